/* rtl/core/spq_pkg.sv */
package spq_pkg;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DUMP   = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_RECORD   = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  // Input beat
  typedef struct packed {
    logic        op;
    logic [15:0] customer_id;
    logic [2:0]  account_class;
    logic [31:0] deposit;
  } in_t;

  // Output beat
  typedef struct packed {
    logic [15:0] rec_customer_id;
    logic [2:0]  rec_class;
    logic [31:0] rec_deposit;
    logic [1:0]  status;
    logic        last;
  } out_t;

  // One stored record
  typedef struct packed {
    logic [2:0]  cls;
    logic [15:0] id;
    logic [31:0] dep;
  } rec_t;

  // Control broadcast to every cell
  typedef struct packed {
    logic insert;
    logic rotate;
    rec_t new_rec;
  } ctl_t;

endpackage

/* rtl/core/sorted_priority_queue.sv */
// Insert: result beat on the next cycle; one insert per cycle
//   while the output is drained, since the shift into the cell row is registered with the beat.
// Dump of n (nonzero) records: n result beats, one per cycle while the output is drained,
//   as the row rotates once per beat; the next item is taken after the last beat is accepted.
// Reset (rst, synchronous): queue empty, no result pending. Record storage is not cleared.
module sorted_priority_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  spq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output spq_pkg::out_t out_data
);
  import spq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_t;

  state_t        state;
  logic [CW-1:0] fill_count;
  logic [CW-1:0] dump_cnt;
  ctl_t          ctl;
  rec_t          recs  [QUEUE_DEPTH];
  logic          keeps [QUEUE_DEPTH];
  logic          occs  [QUEUE_DEPTH];
  logic          in_fire;
  logic          out_free;
  logic          full;
  logic          dump_last;
  logic          load_out;
  out_t          out_next;

  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE) && out_free;
  assign in_fire   = in_valid && in_ready;
  assign full      = (fill_count == CW'(QUEUE_DEPTH));
  assign dump_last = ((dump_cnt + CW'(1)) == fill_count);

  // Cell row
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign occs[i] = (fill_count > CW'(i));
    if (i == 0) begin : g_first
      spq_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .occ       (occs[i]),
        .prev_keep (1'b1),
        .prev_rec  (ctl.new_rec),
        .next_occ  (occs[i+1]),
        .next_rec  (recs[i+1]),
        .head_rec  (recs[0]),
        .rec       (recs[i]),
        .keep      (keeps[i])
      );
    end else if (i == QUEUE_DEPTH - 1) begin : g_tail
      spq_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .occ       (occs[i]),
        .prev_keep (keeps[i-1]),
        .prev_rec  (recs[i-1]),
        .next_occ  (1'b0),
        .next_rec  (recs[0]),
        .head_rec  (recs[0]),
        .rec       (recs[i]),
        .keep      (keeps[i])
      );
    end else begin : g_mid
      spq_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .occ       (occs[i]),
        .prev_keep (keeps[i-1]),
        .prev_rec  (recs[i-1]),
        .next_occ  (occs[i+1]),
        .next_rec  (recs[i+1]),
        .head_rec  (recs[0]),
        .rec       (recs[i]),
        .keep      (keeps[i])
      );
    end
  end

  // Cell control and next output beat
  always_comb begin
    ctl.insert      = 1'b0;
    ctl.rotate      = 1'b0;
    ctl.new_rec.cls = in_data.account_class;
    ctl.new_rec.id  = in_data.customer_id;
    ctl.new_rec.dep = in_data.deposit;
    load_out        = 1'b0;
    out_next        = '0;
    out_next.last   = 1'b1;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (in_data.op == OP_INSERT) begin
            load_out        = 1'b1;
            ctl.insert      = !full;
            out_next.status = full ? ST_FULL : ST_INSERTED;
          end else if (fill_count == '0) begin
            load_out        = 1'b1;
            out_next.status = ST_EMPTY;
          end
        end
      end
      S_DUMP: begin
        if (out_free) begin
          load_out                 = 1'b1;
          ctl.rotate               = 1'b1;
          out_next.rec_customer_id = recs[0].id;
          out_next.rec_class       = recs[0].cls;
          out_next.rec_deposit     = recs[0].dep;
          out_next.status          = ST_RECORD;
          out_next.last            = dump_last;
        end
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      dump_cnt   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (ctl.insert) begin
        fill_count <= fill_count + CW'(1);
      end
      case (state)
        S_IDLE: begin
          if (in_fire && in_data.op == OP_DUMP && fill_count != '0) begin
            state    <= S_DUMP;
            dump_cnt <= '0;
          end
        end
        S_DUMP: begin
          if (out_free) begin
            dump_cnt <= dump_cnt + CW'(1);
            if (dump_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= out_next;
    end
  end

endmodule

/* rtl/core/spq_cell.sv */
module spq_cell (
  input  logic          clk,
  input  spq_pkg::ctl_t ctl,
  input  logic          occ,
  input  logic          prev_keep,
  input  spq_pkg::rec_t prev_rec,
  input  logic          next_occ,
  input  spq_pkg::rec_t next_rec,
  input  spq_pkg::rec_t head_rec,
  output spq_pkg::rec_t rec,
  output logic          keep
);
  import spq_pkg::*;

  // Record stays in place on insert when it sorts at or before the new one
  assign keep = occ && (rec.cls <= ctl.new_rec.cls);

  // Insert: take the new record at the boundary, shift right past it.
  // Rotate: move left within the occupied run, tail takes the head.
  always_ff @(posedge clk) begin
    if (ctl.insert && !keep) begin
      rec <= prev_keep ? ctl.new_rec : prev_rec;
    end else if (ctl.rotate && occ) begin
      rec <= next_occ ? next_rec : head_rec;
    end
  end

endmodule

/* rtl/core/spq_checker.sv */
module spq_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input spq_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input spq_pkg::out_t out_data
);
  import spq_pkg::*;

  // A stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // No new item is taken while a result waits
  a_no_take_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  // An insert answers on the next cycle with an inserted or full status
  a_insert_answer: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.op == OP_INSERT |=>
      out_valid && (out_data.status == ST_INSERTED || out_data.status == ST_FULL))
    else $error("insert without insert status");

  // Non-record results close their item and carry a zero record class
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_RECORD |->
      out_data.last && out_data.rec_class == 3'd0)
    else $error("status beat malformed");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* tb/tb_sorted_priority_queue.sv */
module tb_sorted_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int DEPTH      = 16;
  localparam int IDLE_LIMIT = 5000;
  localparam int RAND_ITEMS = 100;  // per idling phase

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  sorted_priority_queue #(.QUEUE_DEPTH(DEPTH)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #4 clk = ~clk;

  // Items waiting to be sent, result beats still owed by the block
  in_t  pending_items[$];
  out_t owed_beats[$];

  // Shadow copy of the sorted record store
  rec_t shadow_slots[DEPTH];
  int   shadow_fill = 0;

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic in_taken = 1'b0;
  int   stall_cycles = 0;
  int   err_cnt = 0;
  int   n_insert = 0;
  int   n_dump = 0;
  int   n_full = 0;
  int   n_beats = 0;
  int   inserts_queued = 0;

  // Work out the beats that one accepted item must produce
  task automatic queue_results(in_t item);
    int   pos;
    out_t beat;
    beat = '0;
    if (item.op == OP_INSERT) begin
      n_insert++;
      beat.last = 1'b1;
      if (shadow_fill >= DEPTH) begin
        n_full++;
        beat.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < shadow_fill && shadow_slots[pos].cls <= item.account_class)
          pos++;
        for (int i = shadow_fill; i > pos; i--)
          shadow_slots[i] = shadow_slots[i-1];
        shadow_slots[pos].cls = item.account_class;
        shadow_slots[pos].id  = item.customer_id;
        shadow_slots[pos].dep = item.deposit;
        shadow_fill++;
        beat.status = ST_INSERTED;
      end
      owed_beats.push_back(beat);
    end else begin
      n_dump++;
      if (shadow_fill == 0) begin
        beat.status = ST_EMPTY;
        beat.last   = 1'b1;
        owed_beats.push_back(beat);
      end else begin
        for (int i = 0; i < shadow_fill; i++) begin
          beat.rec_customer_id = shadow_slots[i].id;
          beat.rec_class       = shadow_slots[i].cls;
          beat.rec_deposit     = shadow_slots[i].dep;
          beat.status          = ST_RECORD;
          beat.last            = (i == shadow_fill - 1);
          owed_beats.push_back(beat);
        end
      end
    end
  endtask

  task automatic push_insert(logic [2:0] cls, logic [15:0] id, logic [31:0] dep);
    in_t item;
    item.op            = OP_INSERT;
    item.customer_id   = id;
    item.account_class = cls;
    item.deposit       = dep;
    pending_items.push_back(item);
    inserts_queued++;
  endtask

  // Dump beats carry random don't-care fields
  task automatic push_dump();
    in_t item;
    item.op            = OP_DUMP;
    item.customer_id   = 16'($urandom);
    item.account_class = 3'($urandom_range(7));
    item.deposit       = $urandom;
    pending_items.push_back(item);
  endtask

  task automatic push_random();
    logic [2:0] cls;
    // before the store fills, lean toward inserts to build deeper orderings
    if ($urandom_range(99) < ((inserts_queued < DEPTH) ? 25 : 45)) begin
      push_dump();
    end else begin
      cls = ($urandom_range(99) < 85) ? 3'($urandom_range(4, 1)) : 3'($urandom_range(7));
      push_insert(cls, 16'($urandom), $urandom);
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || owed_beats.size() != 0)
      @(posedge clk);
  endtask

  // Driver: new beat at the falling edge, held until taken
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver backpressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor, checker and watchdog
  always @(posedge clk) begin
    out_t want;
    in_taken = 1'b0;
    if (!rst) begin
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        queue_results(in_data);
      end
      if (out_valid && out_ready) begin
        n_beats++;
        if (owed_beats.size() == 0) begin
          $error("unexpected result beat: %p", out_data);
          err_cnt++;
        end else begin
          want = owed_beats.pop_front();
          if (out_data.rec_customer_id !== want.rec_customer_id) begin
            $error("rec_customer_id: expected %0h, got %0h",
                   want.rec_customer_id, out_data.rec_customer_id);
            err_cnt++;
          end
          if (out_data.rec_class !== want.rec_class) begin
            $error("rec_class: expected %0d, got %0d", want.rec_class, out_data.rec_class);
            err_cnt++;
          end
          if (out_data.rec_deposit !== want.rec_deposit) begin
            $error("rec_deposit: expected %0h, got %0h",
                   want.rec_deposit, out_data.rec_deposit);
            err_cnt++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            err_cnt++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_data.last);
            err_cnt++;
          end
        end
      end
      if (in_taken || (out_valid && out_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no beat moved in %0d cycles", IDLE_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Directed: empty dump, field extremes, odd classes, order within a class
    send_idle_pct = 6;
    recv_idle_pct = 72;
    push_dump();
    push_insert(3'd4, 16'hFFFF, 32'hFFFF_FFFF);
    push_insert(3'd1, 16'h0000, 32'h0000_0000);
    push_insert(3'd0, 16'h1234, 32'h0000_0001);
    push_insert(3'd7, 16'h8000, 32'h8000_0000);
    push_insert(3'd1, 16'h0001, 32'h7FFF_FFFF);
    push_insert(3'd3, 16'h7FFF, 32'h5555_AAAA);
    push_dump();
    push_insert(3'd2, 16'hAAAA, 32'hAAAA_5555);
    push_insert(3'd5, 16'h5555, 32'h0000_FFFF);
    push_insert(3'd6, 16'h00FF, 32'hFFFF_0000);
    push_insert(3'd4, 16'hFF00, 32'h0000_0000);
    push_dump();
    wait_drained();

    // Random: sender lightly idle, receiver mostly stalled
    for (int k = 0; k < RAND_ITEMS; k++) push_random();
    wait_drained();

    // Random: roles swapped
    send_idle_pct = 72;
    recv_idle_pct = 6;
    for (int k = 0; k < RAND_ITEMS; k++) push_random();
    wait_drained();

    // Random: full throughput
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int k = 0; k < RAND_ITEMS; k++) push_random();
    wait_drained();

    repeat (20) @(posedge clk);

    $display("Covered %0d inserts (%0d refused as full) and %0d dumps",
             n_insert, n_full, n_dump);
    $display("Checked %0d result beats across three backpressure profiles", n_beats);
    if (err_cnt == 0 && owed_beats.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue.sv
rtl/core/spq_checker.sv
tb/tb_sorted_priority_queue.sv
